// ===== design/ogma_pkg.sv =====
// Shared constants and types for the outlier-gated moving average block.
`default_nettype none
package ogma_pkg;

  localparam int WINDOW_DEPTH    = 8;
  localparam int DATA_W          = 8;
  localparam int CNT_W           = $clog2(WINDOW_DEPTH + 1);
  // Window sum plus the rounding term stays below 256 times the depth.
  localparam int SUM_W           = DATA_W + ((WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1);
  localparam int ITER_W          = $clog2(SUM_W + 1);
  localparam logic [DATA_W-1:0] THRESHOLD_RESET = DATA_W'(20);

  typedef struct packed {
    logic shift;
    logic clear;
  } ogma_cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/ogma_cell.sv =====
// One window cell: holds a sample and its valid bit, adds it into the passing partial sum.
`default_nettype none
module ogma_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ogma_pkg::ogma_cell_ctl_t    ctl,
  input  wire logic [ogma_pkg::DATA_W-1:0] nb_val,
  input  wire logic                        nb_vld,
  input  wire logic [ogma_pkg::SUM_W-1:0]  psum_in,
  output logic      [ogma_pkg::DATA_W-1:0] val,
  output logic                             vld,
  output logic      [ogma_pkg::SUM_W-1:0]  psum_out
);

  logic [ogma_pkg::DATA_W-1:0] val_r;
  logic                        vld_r;
  logic [ogma_pkg::SUM_W-1:0]  psum_r;
  logic [ogma_pkg::SUM_W-1:0]  psum_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.clear) begin
      vld_r <= 1'b0;
    end else if (ctl.shift) begin
      vld_r <= nb_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      val_r <= nb_val;
    end
  end

  always_comb begin
    psum_nxt = psum_in;
    if (vld_r) begin
      psum_nxt = psum_in + ogma_pkg::SUM_W'(val_r);
    end
  end

  always_ff @(posedge clk) begin
    psum_r <= psum_nxt;
  end

  assign val      = val_r;
  assign vld      = vld_r;
  assign psum_out = psum_r;

endmodule
`default_nettype wire

// ===== design/ogma_div.sv =====
// Restoring divider, one quotient bit per cycle, for the window mean.
`default_nettype none
module ogma_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [ogma_pkg::SUM_W-1:0]  dividend,
  input  wire logic [ogma_pkg::CNT_W-1:0]  divisor,
  output logic                             done,
  output logic      [ogma_pkg::DATA_W-1:0] quotient
);

  logic [ogma_pkg::SUM_W-1:0]  dvd_r;
  logic [ogma_pkg::CNT_W-1:0]  dsr_r;
  logic [ogma_pkg::CNT_W-1:0]  rem_r;
  logic [ogma_pkg::ITER_W-1:0] it_r;
  logic                        busy_r;
  logic                        done_r;
  logic [ogma_pkg::CNT_W:0]    shifted;
  logic [ogma_pkg::CNT_W:0]    diff;
  logic                        ge;

  always_comb begin
    shifted = {rem_r, dvd_r[ogma_pkg::SUM_W-1]};
    diff    = shifted - {1'b0, dsr_r};
    ge      = (shifted >= {1'b0, dsr_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= ogma_pkg::ITER_W'(ogma_pkg::SUM_W);
      end else if (busy_r) begin
        it_r <= it_r - 1'b1;
        if (it_r == ogma_pkg::ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The dividend register fills with quotient bits from the bottom as it shifts out.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[ogma_pkg::SUM_W-2:0], ge};
      rem_r <= ge ? diff[ogma_pkg::CNT_W-1:0] : shifted[ogma_pkg::CNT_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r[ogma_pkg::DATA_W-1:0];

endmodule
`default_nettype wire

// ===== design/outlier_gated_moving_average_top.sv =====
// Top level of the outlier-gated moving average: control, window cell row and divider.
//
// Usage: one input word carries a heart-rate reading (in_reading) or a no-reading
// mark (in_no_reading); each input word yields exactly one output word with the
// smoothed rate, the raw rate and a reject flag. Both channels use valid/ready.
// The user must write the threshold register through cfg_wr_en/cfg_wr_data only
// while idle; the block itself does not enforce this. Flow: for a no-reading or
// a rejected reading the block goes from accept to S_DONE, which, once the output
// register is free, loads it and returns to idle. An accepted reading shifts into
// the cell row, then the partial sum walks the row of WINDOW_DEPTH cells and the
// serial divider produces one quotient bit a cycle, SUM_W bits in all, before
// S_DONE. One word is processed at a time, so the next input word is taken only
// once the block is back in idle. The result sits in an output register, so a
// new input word is taken while the previous result waits; the block then holds
// its next result until the receiver takes the pending one.
// Reset empties the window, clears the control state and sets the threshold to 20.
`default_nettype none
module outlier_gated_moving_average_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_reading,
  input  wire logic       in_no_reading,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] out_smoothed_rate,
  output logic      [7:0] out_raw_rate,
  output logic            out_rejected,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);

  localparam int D  = ogma_pkg::WINDOW_DEPTH;
  localparam int DW = ogma_pkg::DATA_W;
  localparam int CW = ogma_pkg::CNT_W;
  localparam int SW = ogma_pkg::SUM_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SUM  = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t       state_r, state_nxt;
  logic [DW-1:0] thr_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] sc_r, sc_nxt;
  logic [DW-1:0] last_r, last_nxt;
  logic [DW-1:0] smooth_r, smooth_nxt;
  logic [DW-1:0] raw_r, raw_nxt;
  logic          rej_r, rej_nxt;
  logic          ov_r;
  logic [DW-1:0] os_r, or_r;
  logic          oj_r;

  logic          in_acc;
  logic [DW-1:0] diff;
  logic          too_far;
  logic          out_free;
  logic          div_start;
  logic          div_done;
  logic [DW-1:0] div_q;
  ogma_pkg::ogma_cell_ctl_t cell_ctl;

  logic [DW-1:0] val_w  [D+1];
  logic          vld_w  [D+1];
  logic [SW-1:0] psum_w [D+1];

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !ov_r || out_ready;

  always_comb begin
    diff    = (in_reading >= last_r) ? (in_reading - last_r) : (last_r - in_reading);
    too_far = (cnt_r != '0) && (diff > thr_r);
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    sc_nxt         = sc_r;
    last_nxt       = last_r;
    smooth_nxt     = smooth_r;
    raw_nxt        = raw_r;
    rej_nxt        = rej_r;
    cell_ctl.shift = 1'b0;
    cell_ctl.clear = 1'b0;
    div_start      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rej_nxt = 1'b0;
          if (in_no_reading) begin
            cell_ctl.clear = 1'b1;
            cnt_nxt        = '0;
            last_nxt       = '0;
            smooth_nxt     = '0;
            raw_nxt        = '0;
            state_nxt      = S_DONE;
          end else if (too_far) begin
            raw_nxt   = in_reading;
            rej_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else begin
            raw_nxt        = in_reading;
            last_nxt       = in_reading;
            cell_ctl.shift = 1'b1;
            if (cnt_r != CW'(D)) begin
              cnt_nxt = cnt_r + 1'b1;
            end
            sc_nxt    = '0;
            state_nxt = S_SUM;
          end
        end
      end
      S_SUM: begin
        // The sum at the end of the row is complete once it has passed every cell.
        if (sc_r == CW'(D)) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          sc_nxt = sc_r + 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          smooth_nxt = div_q;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      thr_r    <= ogma_pkg::THRESHOLD_RESET;
      cnt_r    <= '0;
      sc_r     <= '0;
      last_r   <= '0;
      smooth_r <= '0;
      raw_r    <= '0;
      rej_r    <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      sc_r     <= sc_nxt;
      last_r   <= last_nxt;
      smooth_r <= smooth_nxt;
      raw_r    <= raw_nxt;
      rej_r    <= rej_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      if (state_r == S_DONE && out_free) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      os_r <= smooth_r;
      or_r <= raw_r;
      oj_r <= rej_r;
    end
  end

  assign out_valid         = ov_r;
  assign out_smoothed_rate = os_r;
  assign out_raw_rate      = or_r;
  assign out_rejected      = oj_r;

  // New samples enter at the top cell; the oldest drops out of cell zero.
  assign val_w[D]  = in_reading;
  assign vld_w[D]  = 1'b1;
  assign psum_w[0] = '0;

  for (genvar i = 0; i < D; i++) begin : g_cell
    ogma_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .nb_val   (val_w[i+1]),
      .nb_vld   (vld_w[i+1]),
      .psum_in  (psum_w[i]),
      .val      (val_w[i]),
      .vld      (vld_w[i]),
      .psum_out (psum_w[i+1])
    );
  end

  ogma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (psum_w[D] + SW'(cnt_r >> 1)),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule
`default_nettype wire
